### hdl/ett_pkg.sv
// ----------------------------------------------------------------------------
// ett_pkg: shared types and constants for the encoder angle turn tracker
// Register indexes, fixed field widths and the pole pair reset value.
// ----------------------------------------------------------------------------
package ett_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ZERO_OFFSET = 2'd0,
		CFG_POLE_PAIRS  = 2'd1,
		CFG_REVERSE     = 2'd2
	} cfg_index_t;

	// fixed widths
	localparam int TURN_W = 32;
	localparam int PP_W   = 6;

	// reset value of the pole pair count
	localparam logic [PP_W-1:0] PP_RESET = 6'd4;

endpackage

### hdl/ett_angle.sv
// ----------------------------------------------------------------------------
// ett_angle: mechanical and electrical angle
// Mirrors the raw angle when reversal is set, then scales the offset-corrected
// angle by the pole pair count modulo one revolution.
// ----------------------------------------------------------------------------
module ett_angle #(
	parameter int ANGLE_BITS = 14
) (
	input  logic [ANGLE_BITS-1:0]        raw_angle,
	input  logic [ANGLE_BITS-1:0]        zero_offset,
	input  logic [ett_pkg::PP_W-1:0]     pole_pairs,
	input  logic                         reverse_direction,
	output logic [ANGLE_BITS-1:0]        mech_angle,
	output logic [ANGLE_BITS-1:0]        elec_angle
);

	logic [ANGLE_BITS-1:0]                rel_angle;
	logic [ANGLE_BITS+ett_pkg::PP_W-1:0] elec_full;

	// mirror as (N - raw) mod N, which is the two's complement in ANGLE_BITS
	always_comb begin
		if (reverse_direction) begin
			mech_angle = ANGLE_BITS'(~raw_angle + ANGLE_BITS'(1));
		end else begin
			mech_angle = raw_angle;
		end
	end

	// subtract offset mod N, scale, keep one revolution
	assign rel_angle  = mech_angle - zero_offset;
	assign elec_full  = rel_angle * pole_pairs;
	assign elec_angle = elec_full[ANGLE_BITS-1:0];

endmodule

### hdl/ett_turn.sv
// ----------------------------------------------------------------------------
// ett_turn: turn counter
// Holds the previous mechanical angle and the wrapping turn count; a jump of
// more than half a revolution counts a wrap in the opposite direction.
// ----------------------------------------------------------------------------
module ett_turn #(
	parameter int ANGLE_BITS = 14
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             upd,
	input  logic [ANGLE_BITS-1:0]            angle,
	output logic [ett_pkg::TURN_W-1:0]       turn_next
);

	localparam logic [ANGLE_BITS-1:0] HALF_REV = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

	logic [ANGLE_BITS-1:0]      prev_q;
	logic [ett_pkg::TURN_W-1:0] turn_q;
	logic [ANGLE_BITS-1:0]      jump_up;
	logic [ANGLE_BITS-1:0]      jump_down;

	// distance in each direction, valid only for the matching compare
	assign jump_up   = angle - prev_q;
	assign jump_down = prev_q - angle;

	// next turn count
	always_comb begin
		turn_next = turn_q;
		if (angle > prev_q) begin
			if (jump_up > HALF_REV) begin
				turn_next = turn_q - ett_pkg::TURN_W'(1);
			end
		end else if (jump_down > HALF_REV) begin
			turn_next = turn_q + ett_pkg::TURN_W'(1);
		end
	end

	// state update per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			turn_q <= '0;
		end else if (upd) begin
			prev_q <= angle;
			turn_q <= turn_next;
		end
	end

`ifndef SYNTH
	// previous angle tracks the last item
	a_prev_follows: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> prev_q == $past(angle))
		else $error("previous angle not updated");

	// no item, no change of the turn count
	a_turn_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(turn_q))
		else $error("turn count changed without an item");

	// same angle twice never counts a turn
	a_same_angle: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && angle == prev_q) |=> $stable(turn_q))
		else $error("turn counted without motion");

	// at most one turn per item
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> (turn_q == $past(turn_q)) ||
			(turn_q == $past(turn_q) + ett_pkg::TURN_W'(1)) ||
			(turn_q == $past(turn_q) - ett_pkg::TURN_W'(1)))
		else $error("turn count moved by more than one");
`endif

endmodule

### hdl/encoder_angle_turn_tracker.sv
// ----------------------------------------------------------------------------
// encoder_angle_turn_tracker: multi-turn position from an absolute encoder
// Pipeline: input register, then result register, with the turn counter
//   update between the two; throughput: one item per cycle while the
//   receiver keeps taking results from the result register.
// Reset: arst_n clears the pipeline, angle history and turn count, and loads
//   the configuration defaults (offset 0, four pole pairs, no reversal).
// ----------------------------------------------------------------------------
module encoder_angle_turn_tracker #(
	parameter int ANGLE_BITS = 14
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// configuration
	input  logic                                      cfg_we,
	input  logic [ett_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [ANGLE_BITS-1:0]                     cfg_data,
	// input channel
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic [ANGLE_BITS-1:0]                     raw_angle,
	// output channel
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [ANGLE_BITS-1:0]                     mech_angle,
	output logic [ANGLE_BITS-1:0]                     elec_angle,
	output logic signed [ett_pkg::TURN_W-1:0]         turn_total,
	output logic signed [ett_pkg::TURN_W+ANGLE_BITS-1:0] position
);

	logic [ANGLE_BITS-1:0]        zero_offset_q;
	logic [ett_pkg::PP_W-1:0]     pole_pairs_q;
	logic                         reverse_q;

	logic                         valid_s1;
	logic [ANGLE_BITS-1:0]        raw_s1;
	logic                         advance;
	logic [ANGLE_BITS-1:0]        mech_c;
	logic [ANGLE_BITS-1:0]        elec_c;
	logic [ett_pkg::TURN_W-1:0]   turn_c;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_offset_q <= '0;
			pole_pairs_q  <= ett_pkg::PP_RESET;
			reverse_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ett_pkg::CFG_ZERO_OFFSET: zero_offset_q <= cfg_data;
				ett_pkg::CFG_POLE_PAIRS:  pole_pairs_q  <= cfg_data[ett_pkg::PP_W-1:0];
				ett_pkg::CFG_REVERSE:     reverse_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake: result register frees when taken, input stage moves on then
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_s1 <= raw_angle;
		end
	end

	// angle math
	ett_angle #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_angle (
		.raw_angle        (raw_s1),
		.zero_offset      (zero_offset_q),
		.pole_pairs       (pole_pairs_q),
		.reverse_direction(reverse_q),
		.mech_angle       (mech_c),
		.elec_angle       (elec_c)
	);

	// turn tracking, updated as the item moves into the result register
	ett_turn #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_turn (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (advance),
		.angle    (mech_c),
		.turn_next(turn_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mech_angle <= mech_c;
			elec_angle <= elec_c;
			turn_total <= turn_c;
			// turns * N + angle with 0 <= angle < N is a plain concatenation
			position   <= {turn_c, mech_c};
		end
	end

endmodule

### tb/encoder_angle_turn_tracker_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_angle_turn_tracker_check: result checker for the turn tracker
// Follows the register writes, predicts mechanical angle, electrical angle,
// turn count and position for every accepted item, and compares each
// accepted result in order with the oldest prediction.
// ----------------------------------------------------------------------------
module encoder_angle_turn_tracker_check #(
	parameter int ANGLE_BITS = 14
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         cfg_we,
	input  logic [ett_pkg::CFG_IDX_W-1:0]                cfg_index,
	input  logic [ANGLE_BITS-1:0]                        cfg_data,
	input  logic                                         in_valid,
	input  logic                                         in_ready,
	input  logic [ANGLE_BITS-1:0]                        raw_angle,
	input  logic                                         out_valid,
	input  logic                                         out_ready,
	input  logic [ANGLE_BITS-1:0]                        mech_angle,
	input  logic [ANGLE_BITS-1:0]                        elec_angle,
	input  logic signed [ett_pkg::TURN_W-1:0]            turn_total,
	input  logic signed [ett_pkg::TURN_W+ANGLE_BITS-1:0] position,
	output int                                           fail_count,
	output int                                           waiting
);

	localparam int HALF_REV = 1 << (ANGLE_BITS - 1);

	typedef struct packed {
		logic [ANGLE_BITS-1:0]                        mech;
		logic [ANGLE_BITS-1:0]                        elec;
		logic signed [ett_pkg::TURN_W-1:0]            turns;
		logic signed [ett_pkg::TURN_W+ANGLE_BITS-1:0] pos;
	} sample_t;

	// shadow of the configuration registers
	logic [ANGLE_BITS-1:0]     zero_ofs;
	logic [ett_pkg::PP_W-1:0]  pp;
	logic                      rev;

	// tracking state
	logic [ANGLE_BITS-1:0]      last_angle;
	logic [ett_pkg::TURN_W-1:0] turns;

	sample_t pending_samples[$];
	int      result_no;

	// expected result for one raw sample, given the current tracking state
	function automatic sample_t predict_sample(input logic [ANGLE_BITS-1:0] raw);
		sample_t                             s;
		logic [ANGLE_BITS-1:0]               shifted;
		logic [ANGLE_BITS+ett_pkg::PP_W-1:0] scaled;
		logic [ett_pkg::TURN_W-1:0]          t;
		s.mech = raw;
		if (rev)
			s.mech = ~raw + 1'b1;
		shifted = s.mech - zero_ofs;
		scaled = shifted * pp;
		s.elec = scaled[ANGLE_BITS-1:0];
		// wrap detection: a jump of exactly half a turn counts as no wrap
		t = turns;
		if (s.mech > last_angle) begin
			if (s.mech - last_angle > HALF_REV)
				t = t - 1'b1;
		end else if (last_angle - s.mech > HALF_REV) begin
			t = t + 1'b1;
		end
		s.turns = t;
		s.pos = {t, s.mech};
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_t want;
		if (!arst_n) begin
			zero_ofs = '0;
			pp = ett_pkg::PP_RESET;
			rev = 1'b0;
			last_angle = '0;
			turns = '0;
			pending_samples.delete();
			fail_count = 0;
			result_no = 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					ett_pkg::CFG_ZERO_OFFSET: zero_ofs = cfg_data;
					ett_pkg::CFG_POLE_PAIRS:  pp = cfg_data[ett_pkg::PP_W-1:0];
					ett_pkg::CFG_REVERSE:     rev = cfg_data[0];
					default: ;
				endcase
			end
			// accepted result against the oldest prediction
			if (out_valid && out_ready) begin
				if (pending_samples.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%t: result %0d arrived with no item outstanding",
							$realtime, result_no);
				end else begin
					want = pending_samples.pop_front();
					if (mech_angle !== want.mech || elec_angle !== want.elec ||
						turn_total !== want.turns || position !== want.pos) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%t: result %0d mismatch:", $realtime, result_no,
								" exp mech=%0d elec=%0d turns=%0d pos=%0d,",
								want.mech, want.elec, want.turns, want.pos,
								" got mech=%0d elec=%0d turns=%0d pos=%0d",
								mech_angle, elec_angle, turn_total, position);
					end
				end
				result_no++;
			end
			// accepted item: predict and advance the tracking state
			if (in_valid && in_ready) begin
				want = predict_sample(raw_angle);
				last_angle = want.mech;
				turns = want.turns;
				pending_samples.push_back(want);
			end
		end
		waiting = pending_samples.size();
	end

endmodule

### tb/encoder_angle_turn_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_angle_turn_tracker_test: testbench for the encoder turn tracker
// Drives directed angle walks (wrap edges, half-turn jumps, extreme settings)
// and then random shaft motion under several register settings and handshake
// stall patterns; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module encoder_angle_turn_tracker_test;

	localparam int ANGLE_BITS    = 14;
	localparam int HALF_REV      = 1 << (ANGLE_BITS - 1);
	localparam int SEGMENTS      = 6;
	localparam int SEGMENT_ITEMS = 155;

	localparam logic [ANGLE_BITS-1:0] RESET_WALK [9] =
		'{14'd12000, 14'd16383, 14'd0, 14'd8192, 14'd0, 14'd8193, 14'd0, 14'd1, 14'd16383};
	localparam logic [ANGLE_BITS-1:0] MIRROR_WALK [5] =
		'{14'd0, 14'd1, 14'd16383, 14'd8192, 14'd8191};

	logic                                         clk = 1'b0;
	logic                                         arst_n = 1'b0;
	logic                                         cfg_we = 1'b0;
	logic [ett_pkg::CFG_IDX_W-1:0]                cfg_index = ett_pkg::CFG_ZERO_OFFSET;
	logic [ANGLE_BITS-1:0]                        cfg_data = '0;
	logic                                         in_valid = 1'b0;
	logic                                         in_ready;
	logic [ANGLE_BITS-1:0]                        raw_angle = '0;
	logic                                         out_valid;
	logic                                         out_ready = 1'b0;
	logic [ANGLE_BITS-1:0]                        mech_angle;
	logic [ANGLE_BITS-1:0]                        elec_angle;
	logic signed [ett_pkg::TURN_W-1:0]            turn_total;
	logic signed [ett_pkg::TURN_W+ANGLE_BITS-1:0] position;

	int                    fail_count;
	int                    waiting;
	int                    send_idle_pct = 24;
	int                    recv_stall_pct = 81;
	logic [ANGLE_BITS-1:0] shaft = '0;
	int                    velocity = 0;

	always #1 clk = ~clk;

	encoder_angle_turn_tracker #(
		.ANGLE_BITS(ANGLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_angle(raw_angle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mech_angle(mech_angle),
		.elec_angle(elec_angle),
		.turn_total(turn_total),
		.position(position)
	);

	encoder_angle_turn_tracker_check #(
		.ANGLE_BITS(ANGLE_BITS)
	) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_angle(raw_angle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mech_angle(mech_angle),
		.elec_angle(elec_angle),
		.turn_total(turn_total),
		.position(position),
		.fail_count(fail_count),
		.waiting(waiting)
	);

	// receiver back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// one item, with random idle cycles ahead of it; returns at a falling edge
	task automatic send_angle(input logic [ANGLE_BITS-1:0] angle);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		raw_angle <= angle;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// hold off until all results are back, then write all three registers
	task automatic drain_and_load(input logic [ANGLE_BITS-1:0] ofs,
		input logic [ANGLE_BITS-1:0] pp_val, input logic [ANGLE_BITS-1:0] rev_val);
		in_valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ett_pkg::CFG_ZERO_OFFSET;
		cfg_data <= ofs;
		@(negedge clk);
		cfg_index <= ett_pkg::CFG_POLE_PAIRS;
		cfg_data <= pp_val;
		@(negedge clk);
		cfg_index <= ett_pkg::CFG_REVERSE;
		cfg_data <= rev_val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// random shaft motion: mostly steady spin, some half-turn jumps, some noise
	task automatic spin_segment(input int count);
		int pick;
		int jump;
		repeat (count) begin
			pick = int'($urandom_range(99));
			if ($urandom_range(19) == 0)
				velocity = int'($urandom_range(14000)) - 7000;
			if (pick < 75) begin
				shaft = ANGLE_BITS'(int'(shaft) + velocity + int'($urandom_range(40)) - 20);
			end else if (pick < 88) begin
				jump = HALF_REV - 1 + int'($urandom_range(2));
				if ($urandom_range(1))
					shaft = ANGLE_BITS'(int'(shaft) + jump);
				else
					shaft = ANGLE_BITS'(int'(shaft) - jump);
			end else begin
				shaft = ANGLE_BITS'($urandom);
			end
			send_angle(shaft);
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default settings: first sample above half a turn, wrap edges, exact half jumps
		for (int i = 0; i < 9; i++)
			send_angle(RESET_WALK[i]);

		// largest offset and pole count, mirrored direction
		drain_and_load(14'd16383, 14'd63, 14'd1);
		for (int i = 0; i < 5; i++)
			send_angle(MIRROR_WALK[i]);

		// zero pole pairs: electrical angle stays zero
		drain_and_load(14'd0, 14'd0, 14'd0);
		repeat (4) send_angle(ANGLE_BITS'($urandom));

		// single pole pair, half-turn offset
		drain_and_load(14'd8192, 14'd1, 14'd0);
		repeat (4) send_angle(ANGLE_BITS'($urandom));

		// random motion under random settings and three stall patterns
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain_and_load(ANGLE_BITS'($urandom), ANGLE_BITS'($urandom),
				ANGLE_BITS'($urandom));
			if (seg < 2) begin
				send_idle_pct = 24;
				recv_stall_pct = 81;
			end else if (seg < 4) begin
				send_idle_pct = 81;
				recv_stall_pct = 24;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			spin_segment(SEGMENT_ITEMS);
		end
		in_valid <= 1'b0;

		while (waiting != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0 && waiting == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// run limit
	initial begin
		#400000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
